FILE: src/tterm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tterm_pkg
// Shared constants and types for the text terminal core.
// ----------------------------------------------------------------------------
package tterm_pkg;

    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int NCELLS = COLS * ROWS;

    localparam int ADDR_W = $clog2(NCELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS + 1);

    localparam logic [1:0] REQ_CHAR  = 2'd0;
    localparam logic [1:0] REQ_COLOR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [7:0] ATTR_NORMAL  = 8'h07;
    localparam logic [7:0] ATTR_REVERSE = 8'h70;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_ESC       = 8'd27;
    localparam logic [7:0] CH_LF        = 8'd10;
    localparam logic [7:0] CH_CR        = 8'd13;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_BS        = 8'd8;

    localparam logic [1:0] ESC_IDLE  = 2'd0;
    localparam logic [1:0] ESC_SEEN  = 2'd1;
    localparam logic [1:0] ESC_CSI   = 2'd2;

    typedef logic [15:0] cell_t;

endpackage

FILE: src/tterm_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_with_ansi_escapes_core
// Text terminal engine: cell store, cursor, attribute and ANSI subset parser.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel s_*: one request per transfer (char byte, set colour or
//    read cell). Result channel m_*: exactly one result per request, giving
//    the cursor position after the request and, for reads, the cell.
//  - One request is worked at a time. A plain character, colour or cursor
//    move passes through ST_OUT before m_valid rises; a read first waits in
//    ST_RDW for the registered read port of the store. The next request is
//    taken only once the result has been transferred.
//  - Scrolling walks the store with one read and one write per cell of the
//    upper rows, then blanks the bottom row. Clear screen writes every cell
//    and erase-line writes up to COLS cells.
//  - After reset a clearing pass writes space on grey (0x0720) to all
//    NCELLS cells, one per cycle; s_ready stays low for that time.
//  - If the receiver stalls, the result is held in the output register and
//    s_ready stays low until it is taken.
// ----------------------------------------------------------------------------
module text_terminal_with_ansi_escapes_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [7:0]  s_char_byte,
    input  logic [3:0]  s_fg_color,
    input  logic [3:0]  s_bg_color,
    input  logic [10:0] s_cell_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [10:0] m_cursor_pos,
    output logic [15:0] m_cell_data,
    output logic        m_read_valid
);
    import tterm_pkg::*;

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_FILL  = 3'd2;
    localparam logic [2:0] ST_SCRR  = 3'd3;  // scroll: issue read
    localparam logic [2:0] ST_SCRW  = 3'd4;  // scroll: write back
    localparam logic [2:0] ST_RDW   = 3'd5;  // read cell: data arriving
    localparam logic [2:0] ST_OUT   = 3'd6;

    // cell store
    cell_t mem [NCELLS];
    cell_t rd_data_reg;
    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    cell_t             wdata;

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rd_data_reg <= mem[raddr];
    end

    logic [2:0]        state_reg, state_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [7:0]        attr_reg, attr_next;
    logic [1:0]        esc_reg, esc_next;
    logic [15:0]       num1_reg, num1_next, num2_reg, num2_next;
    logic              on2_reg, on2_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next, end_reg, end_next;
    logic              mv_reg, mv_next, rv_reg, rv_next;
    logic [15:0]       md_reg, md_next;

    cell_t blank;
    assign blank = {attr_reg, CH_SPACE};

    // digit push with saturation
    function automatic logic [15:0] push_digit(input logic [15:0] n, input logic [3:0] d);
        logic [19:0] v;
        v = {n, 3'b000} + {3'b000, n, 1'b0} + 20'(d);
        return (v > 20'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    logic [ADDR_W-1:0] cur_addr;
    assign cur_addr = ADDR_W'(row_reg * COLS) + ADDR_W'(col_reg);

    always_comb begin
        logic [7:0]       c;
        logic             plain;
        logic [COL_W:0]   ncol;
        logic [ROW_W:0]   nrow;
        logic [15:0]      r16, c16;
        state_next = state_reg; row_next = row_reg; col_next = col_reg;
        attr_next = attr_reg; esc_next = esc_reg; num1_next = num1_reg;
        num2_next = num2_reg; on2_next = on2_reg; ptr_next = ptr_reg;
        end_next = end_reg; mv_next = mv_reg;
        rv_next = rv_reg; md_next = md_reg;
        we = 1'b0; waddr = ptr_reg; wdata = blank; raddr = ptr_reg;
        c = s_char_byte; plain = 1'b0;
        ncol = {1'b0, col_reg}; nrow = {1'b0, row_reg};
        r16 = 16'd0; c16 = 16'd0;
        if (mv_reg && m_ready) mv_next = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                we = 1'b1; wdata = {ATTR_NORMAL, CH_SPACE};
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == ADDR_W'(NCELLS - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid && !mv_reg) begin
                    rv_next = 1'b0; md_next = 16'd0;
                    state_next = ST_OUT;
                    case (s_req_type)
                        REQ_COLOR: attr_next = {s_bg_color, s_fg_color};
                        REQ_READ: begin
                            if (s_cell_index < 11'(NCELLS)) begin
                                raddr = ADDR_W'(s_cell_index);
                                state_next = ST_RDW;
                            end
                        end
                        REQ_CHAR: begin
                            if (esc_reg == ESC_IDLE && c == CH_ESC) begin
                                esc_next = ESC_SEEN; num1_next = 16'd0;
                                num2_next = 16'd0; on2_next = 1'b0;
                            end else if (esc_reg == ESC_SEEN && c == "[") begin
                                esc_next = ESC_CSI;
                            end else if (esc_reg == ESC_CSI) begin
                                if (c == "?") begin
                                end else if (c >= "0" && c <= "9") begin
                                    if (on2_reg) num2_next = push_digit(num2_reg, c[3:0]);
                                    else num1_next = push_digit(num1_reg, c[3:0]);
                                end else if (c == ";") begin
                                    on2_next = 1'b1;
                                end else begin
                                    esc_next = ESC_IDLE;
                                    if (c == "H" || c == "f") begin
                                        r16 = (num1_reg > 0) ? num1_reg - 1'b1 : 16'd0;
                                        c16 = (num2_reg > 0) ? num2_reg - 1'b1 : 16'd0;
                                        row_next = (r16 >= 16'(ROWS)) ? ROW_W'(ROWS - 1)
                                                                      : ROW_W'(r16);
                                        col_next = (c16 >= 16'(COLS)) ? COL_W'(COLS - 1)
                                                                      : COL_W'(c16);
                                    end else if (c == "J" && num1_reg == 16'd2) begin
                                        row_next = '0; col_next = '0;
                                        ptr_next = '0; end_next = ADDR_W'(NCELLS - 1);
                                        state_next = ST_FILL;
                                    end else if (c == "K") begin
                                        ptr_next = cur_addr;
                                        end_next = ADDR_W'(row_reg * COLS)
                                                 + ADDR_W'(COLS - 1);
                                        state_next = ST_FILL;
                                    end else if (c == "m") begin
                                        attr_next = (num1_reg == 16'd7) ? ATTR_REVERSE
                                                                       : ATTR_NORMAL;
                                    end
                                end
                            end else begin
                                esc_next = ESC_IDLE;
                                plain = 1'b1;
                            end
                            if (plain) begin
                                if (c == CH_LF) begin
                                    ncol = '0; nrow = nrow + 1'b1;
                                end else if (c == CH_CR) begin
                                    ncol = '0;
                                end else if (c == CH_TAB) begin
                                    ncol = (ncol + (COL_W+1)'(8)) & ~(COL_W+1)'(7);
                                end else if (c == CH_BS) begin
                                    if (col_reg != '0) begin
                                        ncol = ncol - 1'b1;
                                        we = 1'b1; waddr = cur_addr - 1'b1; wdata = blank;
                                    end
                                end else begin
                                    we = 1'b1; waddr = cur_addr; wdata = {attr_reg, c};
                                    ncol = ncol + 1'b1;
                                end
                                if (ncol >= (COL_W+1)'(COLS)) begin
                                    ncol = '0; nrow = nrow + 1'b1;
                                end
                                col_next = COL_W'(ncol);
                                if (nrow >= (ROW_W+1)'(ROWS)) begin
                                    row_next = ROW_W'(ROWS - 1);
                                    ptr_next = '0; state_next = ST_SCRR;
                                end else begin
                                    row_next = ROW_W'(nrow);
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCRR: begin
                raddr = ptr_reg + ADDR_W'(COLS);
                state_next = ST_SCRW;
            end
            ST_SCRW: begin
                we = 1'b1; wdata = rd_data_reg;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == ADDR_W'((ROWS - 1) * COLS - 1)) begin
                    end_next = ADDR_W'(NCELLS - 1);
                    state_next = ST_FILL;
                end else begin
                    state_next = ST_SCRR;
                end
            end
            ST_FILL: begin
                we = 1'b1; wdata = blank;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == end_reg) state_next = ST_OUT;
            end
            ST_RDW: begin
                md_next = rd_data_reg; rv_next = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!mv_reg) begin
                    mv_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT; row_reg <= '0; col_reg <= '0;
            attr_reg <= ATTR_NORMAL; esc_reg <= ESC_IDLE;
            num1_reg <= '0; num2_reg <= '0; on2_reg <= 1'b0;
            ptr_reg <= '0; mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            row_reg <= row_next; col_reg <= col_next; attr_reg <= attr_next;
            esc_reg <= esc_next; num1_reg <= num1_next; num2_reg <= num2_next;
            on2_reg <= on2_next; ptr_reg <= ptr_next; mv_reg <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        end_reg <= end_next;
        rv_reg <= rv_next; md_reg <= md_next;
    end

    // a held result blocks the input, so the cursor output stays put
    assign s_ready      = (state_reg == ST_IDLE) && !mv_reg;
    assign m_valid      = mv_reg;
    assign m_cursor_pos = 11'(row_reg * COLS + col_reg);
    assign m_cell_data  = md_reg;
    assign m_read_valid = rv_reg;

endmodule

FILE: tb/tb_text_terminal_with_ansi_escapes_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_terminal_with_ansi_escapes_core
// Self-checking bench for the text terminal core. A queue of requests
// (directed corner cases, then escape-heavy random traffic) feeds a bursty
// driver; a monitor with its own stall pattern checks every result against
// a behavioural terminal model kept inside the bench.
// ----------------------------------------------------------------------------
module tb_text_terminal_with_ansi_escapes_core;
    import tterm_pkg::*;

    localparam int LIMIT_CYCLES = 30_000_000;

    typedef struct packed {
        logic [1:0]  req;
        logic [7:0]  chr;
        logic [3:0]  fg;
        logic [3:0]  bg;
        logic [10:0] idx;
    } term_req_t;

    typedef struct packed {
        logic [10:0] pos;
        logic [15:0] data;
        logic        rd_ok;
    } term_res_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_req_type;
    logic [7:0]  s_char_byte;
    logic [3:0]  s_fg_color;
    logic [3:0]  s_bg_color;
    logic [10:0] s_cell_index;
    logic        m_valid;
    logic        m_ready;
    logic [10:0] m_cursor_pos;
    logic [15:0] m_cell_data;
    logic        m_read_valid;

    text_terminal_with_ansi_escapes_core uut (.*);

    // Terminal model state
    logic [15:0] scr [NCELLS];
    int          crow, ccol;
    logic [7:0]  attr;
    logic [1:0]  esc_st;
    int          num_a, num_b;
    bit          on_b;

    term_req_t   pending_reqs[$];
    term_res_t   expected_results[$];
    int          n_errors;
    int          n_checked;
    int          n_reads;
    int          n_sent;
    longint      cycle_cnt;
    bit          hold_off_req;   // ask the receiver to hold off for a long stretch
    bit          hold_off_busy;
    bit          drain_req;      // sender pauses until every result is back
    bit          s_ready_seen;   // input handshake at the last rising edge

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ---------------- model ----------------
    function automatic logic [15:0] blank();
        return {attr, CH_SPACE};
    endfunction

    function automatic void scroll_up();
        if (crow < ROWS) return;
        for (int i = 0; i < (ROWS - 1) * COLS; i++) scr[i] = scr[i + COLS];
        for (int i = (ROWS - 1) * COLS; i < NCELLS; i++) scr[i] = blank();
        crow = ROWS - 1;
    endfunction

    function automatic int add_digit(int n, int d);
        int v;
        v = n * 10 + d;
        return (v > 65535) ? 65535 : v;
    endfunction

    function automatic void put_plain(logic [7:0] c);
        if (c == CH_LF) begin
            ccol = 0;
            crow++;
        end else if (c == CH_CR) begin
            ccol = 0;
        end else if (c == CH_TAB) begin
            ccol = (ccol + 8) & ~7;
        end else if (c == CH_BS) begin
            if (ccol > 0) begin
                ccol--;
                scr[crow * COLS + ccol] = blank();
            end
        end else begin
            scr[crow * COLS + ccol] = {attr, c};
            ccol++;
        end
        if (ccol >= COLS) begin
            ccol = 0;
            crow++;
        end
        scroll_up();
    endfunction

    function automatic void take_char(logic [7:0] c);
        if (esc_st == ESC_IDLE && c == CH_ESC) begin
            esc_st = ESC_SEEN;
            num_a  = 0;
            num_b  = 0;
            on_b   = 1'b0;
            return;
        end
        if (esc_st == ESC_SEEN) begin
            if (c == "[") begin
                esc_st = ESC_CSI;
                return;
            end
            esc_st = ESC_IDLE;
        end
        if (esc_st == ESC_CSI) begin
            if (c == "?") return;
            if (c >= "0" && c <= "9") begin
                if (on_b) num_b = add_digit(num_b, c - "0");
                else      num_a = add_digit(num_a, c - "0");
                return;
            end
            if (c == ";") begin
                on_b = 1'b1;
                return;
            end
            if (c == "H" || c == "f") begin
                crow = (num_a > 0) ? num_a - 1 : 0;
                ccol = (num_b > 0) ? num_b - 1 : 0;
                if (crow >= ROWS) crow = ROWS - 1;
                if (ccol >= COLS) ccol = COLS - 1;
            end else if (c == "J" && num_a == 2) begin
                for (int i = 0; i < NCELLS; i++) scr[i] = blank();
                crow = 0;
                ccol = 0;
            end else if (c == "K") begin
                for (int i = crow * COLS + ccol; i < (crow + 1) * COLS; i++)
                    scr[i] = blank();
            end else if (c == "m") begin
                attr = (num_a == 7) ? ATTR_REVERSE : ATTR_NORMAL;
            end
            esc_st = ESC_IDLE;
            return;
        end
        put_plain(c);
    endfunction

    function automatic term_res_t terminal_step(term_req_t r);
        term_res_t res;
        res = '0;
        if (r.req == REQ_CHAR) begin
            take_char(r.chr);
        end else if (r.req == REQ_COLOR) begin
            attr = {r.bg, r.fg};
        end else if (r.req == REQ_READ) begin
            if (r.idx < NCELLS) begin
                res.data  = scr[r.idx];
                res.rd_ok = 1'b1;
            end
        end
        res.pos = 11'((crow * COLS + ccol) & 'h7FF);
        return res;
    endfunction

    // ---------------- stimulus helpers ----------------
    task automatic push_chr(logic [7:0] c);
        term_req_t r;
        r     = '0;
        r.req = REQ_CHAR;
        r.chr = c;
        r.fg  = 4'($urandom);
        r.bg  = 4'($urandom);
        r.idx = 11'($urandom);
        pending_reqs.push_back(r);
    endtask

    task automatic push_str(string s);
        for (int i = 0; i < s.len(); i++) push_chr(s[i]);
    endtask

    task automatic push_color(logic [3:0] f, logic [3:0] b);
        term_req_t r;
        r     = '0;
        r.req = REQ_COLOR;
        r.fg  = f;
        r.bg  = b;
        r.chr = 8'($urandom);
        r.idx = 11'($urandom);
        pending_reqs.push_back(r);
    endtask

    task automatic push_read(logic [10:0] i);
        term_req_t r;
        r     = '0;
        r.req = REQ_READ;
        r.idx = i;
        r.chr = 8'($urandom);
        pending_reqs.push_back(r);
    endtask

    task automatic push_other();
        term_req_t r;
        r     = term_req_t'($bits(term_req_t)'($urandom));
        r.req = 2'd3;
        pending_reqs.push_back(r);
    endtask

    function automatic string dec_num();
        case ($urandom_range(0, 5))
            0:       return "";
            1:       return "99999999";
            default: return $sformatf("%0d", $urandom_range(0, 90));
        endcase
    endfunction

    task automatic push_random_seq();
        int k;
        k = $urandom_range(0, 99);
        if (k < 40) begin
            push_chr(8'($urandom_range(32, 126)));
        end else if (k < 48) begin
            case ($urandom_range(0, 3))
                0: push_chr(CH_LF);
                1: push_chr(CH_CR);
                2: push_chr(CH_TAB);
                3: push_chr(CH_BS);
            endcase
        end else if (k < 58) begin
            push_str({"\033[", dec_num(), ";", dec_num(),
                      ($urandom_range(0, 1) ? "H" : "f")});
        end else if (k < 62) begin
            push_str({"\033[", ($urandom_range(0, 1) ? "?" : ""), dec_num(), "m"});
        end else if (k < 64) begin
            push_str("\033[K");
        end else if (k < 65) begin
            // clear screen is slow; keep it rare
            push_str({"\033[", ($urandom_range(0, 3) ? "2" : "3"), "J"});
        end else if (k < 69) begin
            // broken or unknown sequences
            push_chr(CH_ESC);
            push_chr(8'($urandom));
            if ($urandom_range(0, 1)) push_chr(8'($urandom));
        end else if (k < 73) begin
            push_chr(8'($urandom));
        end else if (k < 78) begin
            push_color(4'($urandom), 4'($urandom));
        end else if (k < 97) begin
            push_read(11'($urandom_range(0, NCELLS - 1)));
        end else if (k < 98) begin
            push_read(11'($urandom_range(NCELLS, 2047)));
        end else begin
            push_other();
        end
    endtask

    // ---------------- reset, stimulus and end of run ----------------
    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_req_type   = '0;
        s_char_byte  = '0;
        s_fg_color   = '0;
        s_bg_color   = '0;
        s_cell_index = '0;
        m_ready      = 1'b0;
        hold_off_req = 1'b0;
        drain_req    = 1'b0;
        n_errors     = 0;
        n_checked    = 0;
        n_reads      = 0;
        n_sent       = 0;
        attr         = ATTR_NORMAL;
        for (int i = 0; i < NCELLS; i++) scr[i] = {ATTR_NORMAL, CH_SPACE};
        crow   = 0;
        ccol   = 0;
        esc_st = ESC_IDLE;
        num_a  = 0;
        num_b  = 0;
        on_b   = 1'b0;

        // Directed part: corners of every field and each special case.
        push_read(11'd0);
        push_read(11'(NCELLS - 1));
        push_read(11'd2047);                 // beyond the store
        push_str("A\t\010B");                // glyph, tab, backspace erase
        push_chr(CH_CR);
        push_chr(CH_BS);                     // backspace at column 0
        push_color(4'hF, 4'hF);
        push_chr(8'hFF);
        push_color(4'h0, 4'h0);
        push_chr(8'h00);                     // control byte stored as glyph
        push_str("\033\033");                // ESC then non-bracket ESC is a glyph
        push_str("\033[999999;999999H");     // saturation and clamp to bottom right
        push_chr("Z");                       // wraps and scrolls
        push_str("\033[7m");
        push_str("\033[?;5f");
        push_str("\033[K");
        push_str("\033[1J");                 // J other than 2: nothing
        push_str("\033[2J");
        push_other();
        push_str("\033[3x");                 // unknown final
        push_read(11'd0);

        // Random part, with a long hold-off and one drain pause in the middle.
        while (pending_reqs.size() + n_sent < 1800) begin
            push_random_seq();
        end
        // Move to the bottom row and drive three line feeds, each followed by a read, to force scrolling.
        push_str("\033[25;1H");
        repeat (3) begin
            push_chr(CH_LF);
            push_read(11'($urandom_range(0, NCELLS - 1)));
        end

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        wait (n_sent >= 300);
        hold_off_req = 1'b1;
        wait (pending_reqs.size() < 1000);
        drain_req = 1'b1;
        wait (pending_reqs.size() == 0 && !s_valid);
        wait (expected_results.size() == 0);
        repeat (50) @(posedge aclk);

        $display("Covered %0d requests, %0d results checked, %0d cell reads,",
                 n_sent, n_checked, n_reads);
        $display("including escapes, wrap, scroll, clear and erase-line.");
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // ---------------- driver: bursts with random gaps ----------------
    int burst_left;
    int gap_left;
    bit drained;
    always @(negedge aclk) begin
        if (!aresetn) begin
            burst_left <= $urandom_range(1, 30);
            gap_left   <= 0;
            drained    <= 1'b0;
        end else if (s_valid && !(s_ready_seen)) begin
            // transfer still pending: hold payload
        end else if (drain_req && !drained) begin
            // pause until every expected result is back
            s_valid <= 1'b0;
            if (expected_results.size() == 0) drained <= 1'b1;
        end else if (gap_left > 0) begin
            s_valid  <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_reqs.size() > 0) begin
            term_req_t r;
            r = pending_reqs.pop_front();
            s_valid      <= 1'b1;
            s_req_type   <= r.req;
            s_char_byte  <= r.chr;
            s_fg_color   <= r.fg;
            s_bg_color   <= r.bg;
            s_cell_index <= r.idx;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 40);
                gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Registered copy of the input handshake at the last rising edge.
    always @(posedge aclk) begin
        s_ready_seen <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            term_req_t r;
            r = '{s_req_type, s_char_byte, s_fg_color, s_bg_color, s_cell_index};
            expected_results.push_back(terminal_step(r));
            n_sent <= n_sent + 1;
        end
    end

    // ---------------- receiver stall pattern ----------------
    int hold_cnt;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready       <= 1'b0;
            hold_cnt      <= 0;
            hold_off_busy <= 1'b0;
        end else if (hold_off_req && !hold_off_busy) begin
            hold_off_busy <= 1'b1;
            hold_cnt      <= 400;
            m_ready       <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready  <= 1'b0;
        end else if (cycle_cnt % 1024 < 300) begin
            m_ready <= 1'b1;               // stretch with no stalls
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // ---------------- monitor ----------------
    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        n_errors++;
        $display("mismatch %s: got %0h, expected %0h (result %0d)",
                 what, got, want, n_checked);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            term_res_t e;
            if (expected_results.size() == 0) begin
                report("unexpected result", m_cursor_pos, 0);
            end else begin
                e = expected_results.pop_front();
                if (m_cursor_pos !== e.pos)   report("cursor_pos", m_cursor_pos, e.pos);
                if (m_cell_data !== e.data)   report("cell_data", m_cell_data, e.data);
                if (m_read_valid !== e.rd_ok) report("read_valid", m_read_valid, e.rd_ok);
                if (e.rd_ok) n_reads++;
            end
            n_checked++;
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("FAILURE");
            $finish;
        end
    end
    initial cycle_cnt = 0;

endmodule
